/* hw/rtl/kls_pkg.sv */
// shared types and constants for the keyframe light sampler
package kls_pkg;

    localparam int DUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int LANES   = 11;
    localparam int LANE_W  = 26;
    localparam int MAG_W   = 24;
    localparam int PROD_W  = MAG_W + DUR_W;
    localparam int DIV_CW  = 6;

    localparam logic [15:0] DEF_ELAPSED = 16'd1;
    localparam logic [23:0] DEF_POS_Z   = 24'd25600;
    localparam logic [31:0] DEF_COLOR   = 32'hFFFF_FFFF;
    localparam logic [23:0] DEF_RADIUS  = 24'd25600;
    localparam logic [15:0] DEF_INTENS  = 16'd256;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_NOP    = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_DEL_RD,
        ST_DEL_SUB,
        ST_SH_RD,
        ST_SH_WR,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CK,
        ST_NX_RD,
        ST_NX_CK,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        frame_duration;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [31:0]        color_rgba;
        logic [23:0]        light_radius;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic [15:0]        light_intensity;
        logic [5:0]         delete_index;
        logic [31:0]        sample_time;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        elapsed_in_frame;
        logic signed [23:0] out_pos_x;
        logic signed [23:0] out_pos_y;
        logic signed [23:0] out_pos_z;
        logic [31:0]        out_color;
        logic [23:0]        out_radius;
        logic signed [15:0] out_yaw;
        logic signed [15:0] out_pitch;
        logic [15:0]        out_intensity;
    } t_res;

    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic [23:0]      px;
        logic [23:0]      py;
        logic [23:0]      pz;
        logic [31:0]      color;
        logic [23:0]      radius;
        logic [15:0]      yaw;
        logic [15:0]      pitch;
        logic [15:0]      inten;
    } t_frame;

endpackage

/* hw/rtl/keyframe_light_sampler_unit.sv */
// keyframe table with looping time sampler and per-field linear interpolation
//
// channel  signals                          direction
// request  i_in_valid  o_in_stall  i_in_req  in
// result   o_out_valid i_out_stall o_out_res out
//
// add: one table write; delete: read and subtract, then read and write back per later entry
// sample: 32 modulo steps (skipped for a zero total), a read and check per frame walked,
//   a read of the next frame, 1 multiply, 40 divide steps, 1 finish; one request at a time
// synchronous active-low reset clears the frame count and total duration
// a result waits in the output register; the next request is taken meanwhile
module keyframe_light_sampler_unit #(
    parameter int MAX_FRAMES = 64,
    parameter int TIME_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  kls_pkg::t_req  i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output kls_pkg::t_res  o_out_res
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int TW = kls_pkg::DUR_W + CW;
    localparam int DW = kls_pkg::DUR_W;
    localparam int LW = kls_pkg::LANE_W;
    localparam int PW = kls_pkg::PROD_W;
    localparam logic [DW-1:0] DUR_MASK =
        (TIME_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << TIME_BITS) - 64'd1);

    kls_pkg::t_frame r_mem [MAX_FRAMES];
    kls_pkg::t_frame r_rd;
    kls_pkg::t_frame r_a;

    kls_pkg::t_state r_state, n_state;
    kls_pkg::t_req   r_req;
    kls_pkg::t_res   r_pend, n_pend;
    kls_pkg::t_res   r_out, n_out;
    logic            r_out_valid;

    logic [CW-1:0]   r_count;
    logic [TW-1:0]   r_total;
    logic [AW-1:0]   r_i;
    logic [TW-1:0]   r_t;
    logic [31:0]     r_tin;
    logic [TW-1:0]   r_cum;
    logic [DW-1:0]   r_e;
    logic [kls_pkg::DIV_CW-1:0] r_cnt;

    logic signed [LW-1:0]        r_la  [kls_pkg::LANES];
    logic [kls_pkg::MAG_W-1:0]   r_mag [kls_pkg::LANES];
    logic                        r_neg [kls_pkg::LANES];
    logic [PW-1:0]               r_n   [kls_pkg::LANES];
    logic [DW-1:0]               r_rem [kls_pkg::LANES];
    logic [LW-1:0]               r_lr  [kls_pkg::LANES];

    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    kls_pkg::t_frame mem_wdata;

    logic            in_acc;
    logic            out_free;
    logic [TW-1:0]   cum_n;
    logic            hit;
    logic            more_sh;
    logic            idx_bad;
    logic [AW-1:0]   nx;
    logic [TW:0]     m_sh;

    function automatic logic signed [LW-1:0] lane_val(input kls_pkg::t_frame f,
                                                      input int k);
        logic signed [LW-1:0] v;
        case (k)
            0:       v = LW'(signed'(f.px));
            1:       v = LW'(signed'(f.py));
            2:       v = LW'(signed'(f.pz));
            3:       v = LW'({1'b0, f.color[31:24]});
            4:       v = LW'({1'b0, f.color[23:16]});
            5:       v = LW'({1'b0, f.color[15:8]});
            6:       v = LW'({1'b0, f.color[7:0]});
            7:       v = LW'({1'b0, f.radius});
            8:       v = LW'(signed'(f.yaw));
            9:       v = LW'(signed'(f.pitch));
            default: v = LW'({1'b0, f.inten});
        endcase
        return v;
    endfunction

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != kls_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    assign cum_n   = r_cum + TW'(r_rd.dur);
    assign hit     = (cum_n >= r_t);
    assign more_sh = ((CW'(r_i) + CW'(1)) < r_count);
    assign idx_bad = (32'(i_in_req.delete_index) >= 32'(r_count));
    assign nx      = more_sh ? AW'(r_i + AW'(1)) : '0;
    assign m_sh    = {r_t, r_tin[31]};

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kls_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_req.req_type)
                        kls_pkg::REQ_ADD:
                            n_state = (32'(r_count) >= 32'(MAX_FRAMES)) ?
                                      kls_pkg::ST_OUT : kls_pkg::ST_ADD;
                        kls_pkg::REQ_DELETE:
                            n_state = idx_bad ? kls_pkg::ST_OUT : kls_pkg::ST_DEL_RD;
                        kls_pkg::REQ_SAMPLE: begin
                            if (r_count == '0) begin
                                n_state = kls_pkg::ST_OUT;
                            end else if (r_total == '0) begin
                                n_state = kls_pkg::ST_WALK_RD;
                            end else begin
                                n_state = kls_pkg::ST_MOD;
                            end
                        end
                        default: n_state = kls_pkg::ST_OUT;
                    endcase
                end
            end
            kls_pkg::ST_ADD:     n_state = kls_pkg::ST_OUT;
            kls_pkg::ST_DEL_RD:  n_state = kls_pkg::ST_DEL_SUB;
            kls_pkg::ST_DEL_SUB: n_state = more_sh ? kls_pkg::ST_SH_RD : kls_pkg::ST_OUT;
            kls_pkg::ST_SH_RD:   n_state = kls_pkg::ST_SH_WR;
            kls_pkg::ST_SH_WR: begin
                n_state = ((CW'(r_i) + CW'(1)) < r_count) ? kls_pkg::ST_SH_RD :
                          kls_pkg::ST_OUT;
            end
            kls_pkg::ST_MOD: begin
                if (r_cnt == kls_pkg::DIV_CW'(31)) begin
                    n_state = kls_pkg::ST_WALK_RD;
                end
            end
            kls_pkg::ST_WALK_RD: n_state = kls_pkg::ST_WALK_CK;
            kls_pkg::ST_WALK_CK: begin
                n_state = (hit || !more_sh) ? kls_pkg::ST_NX_RD : kls_pkg::ST_WALK_RD;
            end
            kls_pkg::ST_NX_RD:   n_state = kls_pkg::ST_NX_CK;
            kls_pkg::ST_NX_CK:   n_state = kls_pkg::ST_MUL;
            kls_pkg::ST_MUL:     n_state = kls_pkg::ST_DIV;
            kls_pkg::ST_DIV: begin
                if (r_cnt == kls_pkg::DIV_CW'(PW - 1)) begin
                    n_state = kls_pkg::ST_FIN;
                end
            end
            kls_pkg::ST_FIN:     n_state = kls_pkg::ST_OUT;
            kls_pkg::ST_OUT:     n_state = out_free ? kls_pkg::ST_IDLE : kls_pkg::ST_OUT;
            default:             n_state = kls_pkg::ST_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        mem_raddr = r_i;
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_rd;
        case (r_state)
            kls_pkg::ST_ADD: begin
                mem_we    = 1'b1;
                mem_waddr = r_count[AW-1:0];
                mem_wdata.dur    = r_req.frame_duration & DUR_MASK;
                mem_wdata.px     = r_req.pos_x;
                mem_wdata.py     = r_req.pos_y;
                mem_wdata.pz     = r_req.pos_z;
                mem_wdata.color  = r_req.color_rgba;
                mem_wdata.radius = r_req.light_radius;
                mem_wdata.yaw    = r_req.yaw_angle;
                mem_wdata.pitch  = r_req.pitch_angle;
                mem_wdata.inten  = r_req.light_intensity;
            end
            kls_pkg::ST_SH_RD:  mem_raddr = AW'(r_i + AW'(1));
            kls_pkg::ST_SH_WR:  mem_we    = 1'b1;
            kls_pkg::ST_NX_RD:  mem_raddr = nx;
            default: begin
                mem_raddr = r_i;
            end
        endcase
    end

    // pending and final result values
    always_comb begin
        n_pend = '0;
        case (i_in_req.req_type)
            kls_pkg::REQ_ADD: begin
                if (32'(r_count) >= 32'(MAX_FRAMES)) begin
                    n_pend.status = kls_pkg::STS_FULL;
                end
            end
            kls_pkg::REQ_DELETE: begin
                if (idx_bad) begin
                    n_pend.status = kls_pkg::STS_RANGE;
                end
            end
            kls_pkg::REQ_SAMPLE: begin
                if (r_count == '0) begin
                    n_pend.status           = kls_pkg::STS_EMPTY;
                    n_pend.elapsed_in_frame = kls_pkg::DEF_ELAPSED;
                    n_pend.out_pos_z        = kls_pkg::DEF_POS_Z;
                    n_pend.out_color        = kls_pkg::DEF_COLOR;
                    n_pend.out_radius       = kls_pkg::DEF_RADIUS;
                    n_pend.out_intensity    = kls_pkg::DEF_INTENS;
                end
            end
            default: begin
                n_pend.status = kls_pkg::STS_OK;
            end
        endcase
        n_out = r_pend;
        if (r_req.req_type == kls_pkg::REQ_SAMPLE && r_count != '0) begin
            n_out.status           = kls_pkg::STS_OK;
            n_out.elapsed_in_frame = r_e;
            n_out.out_pos_x        = r_lr[0][23:0];
            n_out.out_pos_y        = r_lr[1][23:0];
            n_out.out_pos_z        = r_lr[2][23:0];
            n_out.out_color        = {r_lr[3][7:0], r_lr[4][7:0],
                                      r_lr[5][7:0], r_lr[6][7:0]};
            n_out.out_radius       = r_lr[7][23:0];
            n_out.out_yaw          = r_lr[8][15:0];
            n_out.out_pitch        = r_lr[9][15:0];
            n_out.out_intensity    = r_lr[10][15:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kls_pkg::ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == kls_pkg::ST_ADD) begin
                r_count <= r_count + CW'(1);
                r_total <= r_total + TW'(r_req.frame_duration & DUR_MASK);
            end
            if (r_state == kls_pkg::ST_DEL_SUB) begin
                r_count <= r_count - CW'(1);
                r_total <= r_total - TW'(r_rd.dur);
            end
            if (r_state == kls_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            kls_pkg::ST_IDLE: begin
                r_req  <= i_in_req;
                r_pend <= n_pend;
                r_i    <= (i_in_req.req_type == kls_pkg::REQ_SAMPLE) ?
                          '0 : AW'(i_in_req.delete_index);
                r_t    <= '0;
                r_tin  <= i_in_req.sample_time;
                r_cum  <= '0;
                r_cnt  <= '0;
            end
            kls_pkg::ST_SH_WR: r_i <= AW'(r_i + AW'(1));
            kls_pkg::ST_MOD: begin
                r_tin <= {r_tin[30:0], 1'b0};
                r_cnt <= r_cnt + kls_pkg::DIV_CW'(1);
                if (m_sh >= {1'b0, r_total}) begin
                    r_t <= TW'(m_sh - {1'b0, r_total});
                end else begin
                    r_t <= TW'(m_sh);
                end
            end
            kls_pkg::ST_WALK_CK: begin
                r_e   <= DW'(r_t - r_cum);
                r_a   <= r_rd;
                r_cum <= cum_n;
                if (!(hit || !more_sh)) begin
                    r_i <= AW'(r_i + AW'(1));
                end
            end
            kls_pkg::ST_NX_CK: begin
                r_cnt <= '0;
                for (int k = 0; k < kls_pkg::LANES; k++) begin
                    logic signed [LW-1:0] df;
                    df = lane_val(r_rd, k) - lane_val(r_a, k);
                    r_la[k]  <= lane_val(r_a, k);
                    r_neg[k] <= df[LW-1];
                    r_mag[k] <= df[LW-1] ? kls_pkg::MAG_W'(-df) : kls_pkg::MAG_W'(df);
                end
            end
            kls_pkg::ST_MUL: begin
                for (int k = 0; k < kls_pkg::LANES; k++) begin
                    r_n[k]   <= PW'(r_mag[k]) * PW'(r_e);
                    r_rem[k] <= '0;
                end
            end
            kls_pkg::ST_DIV: begin
                r_cnt <= r_cnt + kls_pkg::DIV_CW'(1);
                for (int k = 0; k < kls_pkg::LANES; k++) begin
                    logic [DW:0] sh;
                    logic        ge;
                    sh = {r_rem[k], r_n[k][PW-1]};
                    ge = (sh >= {1'b0, r_a.dur});
                    r_n[k]   <= {r_n[k][PW-2:0], ge};
                    r_rem[k] <= ge ? DW'(sh - {1'b0, r_a.dur}) : DW'(sh);
                end
            end
            kls_pkg::ST_FIN: begin
                for (int k = 0; k < kls_pkg::LANES; k++) begin
                    logic [LW-1:0] q;
                    q = LW'(r_n[k][kls_pkg::MAG_W-1:0]);
                    if (r_a.dur == '0) begin
                        r_lr[k] <= r_la[k];
                    end else if (r_neg[k]) begin
                        r_lr[k] <= r_la[k] - q - LW'(r_rem[k] != '0);
                    end else begin
                        r_lr[k] <= r_la[k] + q;
                    end
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // result register, loaded as the sequence leaves its last state
    always_ff @(posedge i_clk) begin
        if (r_state == kls_pkg::ST_OUT && out_free) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_FRAMES))
        else $error("frame count above capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request taken while busy");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kls_pkg::ST_WALK_CK || r_state == kls_pkg::ST_DIV) |-> !mem_we)
        else $error("table written during sample");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("nonzero total with empty table");
`endif

endmodule
